// ===== rtl/motion_occupancy_hold_timer_macros.svh =====
// assertion macros for the occupancy hold timer
`ifndef MOTION_OCCUPANCY_HOLD_TIMER_MACROS_SVH
`define MOTION_OCCUPANCY_HOLD_TIMER_MACROS_SVH

// same-cycle implication
`define MOHT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define MOHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/mohtmr_pkg.sv =====
// types and constants shared by the occupancy hold timer
`timescale 1ns / 1ps

package mohtmr_pkg;

    localparam int HOLD_WIDTH      = 16;
    localparam int MUTE_WIDTH      = 16;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 1;

    localparam logic [HOLD_WIDTH-1:0] HOLD_RESET = 16'd50;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_TICKS = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LED_ENABLE = 1'b1;

    localparam logic CMD_SAMPLE   = 1'b0;
    localparam logic CMD_OVERRIDE = 1'b1;

    localparam logic KIND_CHANGE     = 1'b0;
    localparam logic KIND_REANNOUNCE = 1'b1;

    typedef struct packed {
        logic                  command;
        logic                  motion_level;
        logic                  override_state;
        logic [MUTE_WIDTH-1:0] mute_ticks;
    } in_item_t;

    typedef struct packed {
        logic event_state;
        logic event_kind;
        logic led_level;
        logic occupied;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } step_res_t;

endpackage

// ===== rtl/mohtmr_tracker.sv =====
// occupancy state, idle and mute counters and per-item update
`timescale 1ns / 1ps

module mohtmr_tracker #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                fire,
    input  mohtmr_pkg::in_item_t                item,
    input  logic [mohtmr_pkg::HOLD_WIDTH-1:0]   hold_ticks,
    input  logic                                led_enable,
    output mohtmr_pkg::step_res_t               res
);

    localparam int CMP_W =
        (COUNT_WIDTH > mohtmr_pkg::HOLD_WIDTH) ? COUNT_WIDTH : mohtmr_pkg::HOLD_WIDTH;
    localparam int MCMP_W =
        (COUNT_WIDTH > mohtmr_pkg::MUTE_WIDTH) ? COUNT_WIDTH : mohtmr_pkg::MUTE_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                   occupancy_reg, occupancy_next;
    logic                   first_reg, first_next;
    logic [COUNT_WIDTH-1:0] idle_reg, idle_next;
    logic                   handled_reg, handled_next;
    logic                   force_reg, force_next;
    logic [COUNT_WIDTH-1:0] mute_reg, mute_next;
    logic                   led_reg, led_next;

    logic [COUNT_WIDTH-1:0] idle_inc;
    logic [COUNT_WIDTH-1:0] mute_sat;
    logic                   level;
    logic                   report;

    assign idle_inc = (idle_reg == COUNT_MAX) ? idle_reg : idle_reg + 1'b1;
    assign mute_sat = (MCMP_W'(item.mute_ticks) > MCMP_W'(COUNT_MAX)) ?
                      COUNT_MAX : COUNT_WIDTH'(item.mute_ticks);
    assign level    = force_reg | item.motion_level;

    always_comb begin
        occupancy_next = occupancy_reg;
        first_next     = first_reg;
        idle_next      = idle_reg;
        handled_next   = handled_reg;
        force_next     = force_reg;
        mute_next      = mute_reg;
        led_next       = led_reg;
        report         = 1'b0;
        res            = '0;
        if (fire) begin
            if (item.command == mohtmr_pkg::CMD_OVERRIDE) begin
                if (handled_reg != item.override_state) begin
                    handled_next = item.override_state;
                    mute_next    = mute_sat;
                end
            end else if (mute_reg != '0) begin
                mute_next = mute_reg - 1'b1;
                idle_next = idle_inc;
            end else begin
                force_next = 1'b0;
                if (level) begin
                    occupancy_next = 1'b1;
                    idle_next      = '0;
                end else begin
                    idle_next = idle_inc;
                    if (CMP_W'(idle_inc) > CMP_W'(hold_ticks)) begin
                        occupancy_next = 1'b0;
                    end
                end
                report = first_reg | (occupancy_next != occupancy_reg);
                if (report) begin
                    first_next   = 1'b0;
                    handled_next = occupancy_next;
                    led_next     = led_enable ? occupancy_next : led_reg;
                    res.valid            = 1'b1;
                    res.item.event_state = occupancy_next;
                    res.item.event_kind  = mohtmr_pkg::KIND_CHANGE;
                    res.item.led_level   = led_next;
                    res.item.occupied    = occupancy_next;
                end else begin
                    if (level && !handled_reg) begin
                        handled_next = 1'b1;
                        res.valid            = 1'b1;
                        res.item.event_state = 1'b1;
                        res.item.event_kind  = mohtmr_pkg::KIND_REANNOUNCE;
                        res.item.led_level   = led_reg;
                        res.item.occupied    = occupancy_next;
                    end
                    force_next = !occupancy_next && handled_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occupancy_reg <= 1'b0;
            first_reg     <= 1'b1;
            idle_reg      <= '0;
            handled_reg   <= 1'b0;
            force_reg     <= 1'b0;
            mute_reg      <= '0;
            led_reg       <= 1'b0;
        end else begin
            occupancy_reg <= occupancy_next;
            first_reg     <= first_next;
            idle_reg      <= idle_next;
            handled_reg   <= handled_next;
            force_reg     <= force_next;
            mute_reg      <= mute_next;
            led_reg       <= led_next;
        end
    end

endmodule

// ===== rtl/motion_occupancy_hold_timer.sv =====
// Retriggerable occupancy timer with hold time, manual override and mute period.
// Each transfer on the s_ channel is one poll tick or one override command; the
// block takes one transfer per clock and answers each via its input register and
// then its result register, giving at most one status event per transfer on the m_
// channel. The throughput of one transfer per cycle is set by the single occupancy
// update between those registers; it drops only while a result waits on m_ready.
// Write hold_ticks/led_enable via cfg only while idle; the block does not check it.
`timescale 1ns / 1ps

module motion_occupancy_hold_timer #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  mohtmr_pkg::in_item_t                     s_data,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output mohtmr_pkg::out_item_t                    m_data,
    input  logic                                     cfg_wr_en,
    input  logic [mohtmr_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [mohtmr_pkg::CFG_DATA_WIDTH-1:0]    cfg_wr_data
);

    `include "motion_occupancy_hold_timer_macros.svh"

    logic [mohtmr_pkg::HOLD_WIDTH-1:0] hold_ticks_reg;
    logic                              led_enable_reg;

    logic                  in_valid_reg, in_valid_next;
    mohtmr_pkg::in_item_t  in_item_reg;
    logic                  out_valid_reg, out_valid_next;
    mohtmr_pkg::out_item_t out_item_reg;

    logic                  slot_free;
    logic                  proc_fire;
    logic                  s_accept;
    mohtmr_pkg::step_res_t res;

    assign slot_free = !out_valid_reg || m_ready;
    assign proc_fire = in_valid_reg && slot_free;
    assign s_ready   = !in_valid_reg || proc_fire;
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_item_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_ticks_reg <= mohtmr_pkg::HOLD_RESET;
            led_enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mohtmr_pkg::REG_HOLD_TICKS: hold_ticks_reg <= cfg_wr_data;
                mohtmr_pkg::REG_LED_ENABLE: led_enable_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (proc_fire) begin
            out_valid_next = res.valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_data;
        end
        if (proc_fire && res.valid) begin
            out_item_reg <= res.item;
        end
    end

    mohtmr_tracker #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (proc_fire),
        .item       (in_item_reg),
        .hold_ticks (hold_ticks_reg),
        .led_enable (led_enable_reg),
        .res        (res)
    );

    `MOHT_ASSERT_NEXT(a_override_no_result, aclk, aresetn, proc_fire && in_item_reg.command == mohtmr_pkg::CMD_OVERRIDE, !out_valid_reg)
    `MOHT_ASSERT_IMPLY(a_stall_cause, aclk, aresetn, !s_ready, in_valid_reg && out_valid_reg && !m_ready)
    `MOHT_ASSERT_IMPLY(a_change_matches, aclk, aresetn, out_valid_reg && out_item_reg.event_kind == mohtmr_pkg::KIND_CHANGE, out_item_reg.event_state == out_item_reg.occupied)
    `MOHT_ASSERT_IMPLY(a_reannounce_on, aclk, aresetn, out_valid_reg && out_item_reg.event_kind == mohtmr_pkg::KIND_REANNOUNCE, out_item_reg.event_state && out_item_reg.occupied)

endmodule
